### design/lcfc_pkg.sv
// ----------------------------------------------------------------------------
// lcfc_pkg
// Shared types, constants and the bytewise CRC-32 step for the frame checker.
// ----------------------------------------------------------------------------
package lcfc_pkg;

    localparam int unsigned FRAME_LEN_W   = 26;
    localparam int unsigned JOURNAL_W     = 30;
    localparam int unsigned FRAME_CNT_W   = 26;
    localparam int unsigned BYTES_LEFT_W  = 25;

    localparam logic [FRAME_LEN_W-1:0] FRAME_CAP   = 26'd33554432;
    localparam logic [JOURNAL_W-1:0]   JOURNAL_CAP = 30'd536870912;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // register indexes on the config port
    localparam logic REG_MAX_FRAME_LEN     = 1'b0;
    localparam logic REG_MAX_JOURNAL_BYTES = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_FRAME_SIZE  = 3'd1,
        ERR_CRC         = 3'd2,
        ERR_TRUNC_HDR   = 3'd3,
        ERR_TRUNC_FRAME = 3'd4,
        ERR_JOURNAL     = 3'd5
    } t_err;

    typedef struct packed {
        logic [FRAME_LEN_W-1:0] max_frame_len;
        logic [JOURNAL_W-1:0]   max_journal_bytes;
    } t_cfg;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/length_crc_frame_checker.sv
// ----------------------------------------------------------------------------
// length_crc_frame_checker
// Parses a length/CRC-32 framed journal byte stream, passes payload through,
// checks each frame's CRC and reports good frame and prefix byte counts.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_ready    i_data_byte, i_last
//   out       source     o_out_valid / i_out_ready  payload, frame, error, counts
//   cfg       APB slave  psel/penable/pwrite        max_frame_len, max_journal_bytes
//
// One byte per cycle, back to back, while each result is taken. Each byte's
// result is registered at the edge that takes the byte and is offered from
// the next cycle on; the bytewise CRC update and the counters are worked out
// combinationally before that register. A waiting result holds the input off
// unless it is taken in the same cycle. After the first error bytes are still
// taken but yield no result; only reset clears the error. Reset is synchronous.
// ----------------------------------------------------------------------------
module length_crc_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_end,
    output logic        o_frame_ok,
    output logic [2:0]  o_error_code,
    output logic [25:0] o_good_frames,
    output logic [29:0] o_prefix_bytes,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned FLW = lcfc_pkg::FRAME_LEN_W;
    localparam int unsigned JW  = lcfc_pkg::JOURNAL_W;
    localparam int unsigned FCW = lcfc_pkg::FRAME_CNT_W;
    localparam int unsigned BLW = lcfc_pkg::BYTES_LEFT_W;

    lcfc_pkg::t_cfg cfg;

    lcfc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // parser state
    logic [2:0]         r_hdr_idx,    n_hdr_idx;
    logic               r_in_payload, n_in_payload;
    logic [31:0]        r_frame_len,  n_frame_len;
    logic [31:0]        r_exp_crc,    n_exp_crc;
    logic [31:0]        r_crc,        n_crc;
    logic [BLW-1:0]     r_bytes_left, n_bytes_left;
    logic [JW-1:0]      r_total,      n_total;
    logic [FCW-1:0]     r_frames,     n_frames;
    logic [JW-1:0]      r_prefix,     n_prefix;
    lcfc_pkg::t_err     r_err,        n_err;

    // result register
    logic               r_out_valid;
    logic               r_pv,  n_pv;
    logic [7:0]         r_pb,  n_pb;
    logic               r_fe,  n_fe;
    logic               r_fok, n_fok;

    logic               accept;
    logic               emit;
    logic [JW:0]        next_total;
    logic [FLW-1:0]     lim;
    logic [31:0]        crc_upd;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign emit       = accept && (r_err == lcfc_pkg::ERR_NONE);
    assign next_total = {1'b0, r_total} + {{JW{1'b0}}, 1'b1};
    assign lim        = (cfg.max_frame_len > lcfc_pkg::FRAME_CAP) ? lcfc_pkg::FRAME_CAP
                                                                  : cfg.max_frame_len;
    assign crc_upd    = lcfc_pkg::crc_byte(r_crc, i_data_byte);

    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_in_payload = r_in_payload;
        n_frame_len  = r_frame_len;
        n_exp_crc    = r_exp_crc;
        n_crc        = r_crc;
        n_bytes_left = r_bytes_left;
        n_total      = r_total;
        n_frames     = r_frames;
        n_prefix     = r_prefix;
        n_err        = r_err;
        n_pv         = 1'b0;
        n_pb         = 8'd0;
        n_fe         = 1'b0;
        n_fok        = 1'b0;

        if (next_total > {1'b0, cfg.max_journal_bytes}) begin
            n_err = lcfc_pkg::ERR_JOURNAL;
        end else begin
            n_total = next_total[JW-1:0];
            if (!r_in_payload) begin
                case (r_hdr_idx)
                    3'd0: n_frame_len = {24'd0, i_data_byte};
                    3'd1: n_frame_len[15:8]  = i_data_byte;
                    3'd2: n_frame_len[23:16] = i_data_byte;
                    3'd3: n_frame_len[31:24] = i_data_byte;
                    3'd4: n_exp_crc = {24'd0, i_data_byte};
                    3'd5: n_exp_crc[15:8]  = i_data_byte;
                    3'd6: n_exp_crc[23:16] = i_data_byte;
                    default: n_exp_crc[31:24] = i_data_byte;
                endcase
                if (r_hdr_idx == 3'd7) begin
                    n_hdr_idx = 3'd0;
                    if (r_frame_len == 32'd0 || r_frame_len > {6'd0, lim}) begin
                        n_err = lcfc_pkg::ERR_FRAME_SIZE;
                    end else if (i_last) begin
                        n_err = lcfc_pkg::ERR_TRUNC_FRAME;
                    end else begin
                        n_in_payload = 1'b1;
                        // length is at most 2^25 here, so it fits bytes_left
                        n_bytes_left = BLW'(r_frame_len - 32'd1);
                        n_crc        = lcfc_pkg::CRC_INIT;
                    end
                end else begin
                    n_hdr_idx = r_hdr_idx + 3'd1;
                    if (i_last) begin
                        n_err = lcfc_pkg::ERR_TRUNC_HDR;
                    end
                end
            end else begin
                n_pv  = 1'b1;
                n_pb  = i_data_byte;
                n_crc = crc_upd;
                if (r_bytes_left == '0) begin
                    n_fe         = 1'b1;
                    n_in_payload = 1'b0;
                    if (~crc_upd == r_exp_crc) begin
                        n_fok = 1'b1;
                        if (r_frames != '1) begin
                            n_frames = r_frames + FCW'(1);
                        end
                        n_prefix = r_prefix + JW'(8) + r_frame_len[JW-1:0];
                    end else begin
                        n_err = lcfc_pkg::ERR_CRC;
                    end
                end else begin
                    n_bytes_left = r_bytes_left - BLW'(1);
                    if (i_last) begin
                        n_err = lcfc_pkg::ERR_TRUNC_FRAME;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= 3'd0;
            r_in_payload <= 1'b0;
            r_frame_len  <= 32'd0;
            r_exp_crc    <= 32'd0;
            r_crc        <= lcfc_pkg::CRC_INIT;
            r_bytes_left <= '0;
            r_total      <= '0;
            r_frames     <= '0;
            r_prefix     <= '0;
            r_err        <= lcfc_pkg::ERR_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (emit) begin
                r_hdr_idx    <= n_hdr_idx;
                r_in_payload <= n_in_payload;
                r_frame_len  <= n_frame_len;
                r_exp_crc    <= n_exp_crc;
                r_crc        <= n_crc;
                r_bytes_left <= n_bytes_left;
                r_total      <= n_total;
                r_frames     <= n_frames;
                r_prefix     <= n_prefix;
                r_err        <= n_err;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pv  <= n_pv;
            r_pb  <= n_pb;
            r_fe  <= n_fe;
            r_fok <= n_fok;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_pv;
    assign o_payload_byte  = r_pb;
    assign o_frame_end     = r_fe;
    assign o_frame_ok      = r_fok;
    assign o_error_code    = r_err;
    assign o_good_frames   = r_frames;
    assign o_prefix_bytes  = r_prefix;

endmodule

### design/lcfc_apb_regs.sv
// ----------------------------------------------------------------------------
// lcfc_apb_regs
// APB-style register file holding the frame and journal size limits.
// ----------------------------------------------------------------------------
module lcfc_apb_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output lcfc_pkg::t_cfg      o_cfg
);

    logic [lcfc_pkg::FRAME_LEN_W-1:0] r_max_frame_len;
    logic [lcfc_pkg::JOURNAL_W-1:0]   r_max_journal;
    logic                             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // word-aligned bus: only paddr[2] selects the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_len <= lcfc_pkg::FRAME_CAP;
            r_max_journal   <= lcfc_pkg::JOURNAL_CAP;
        end else if (wr_en) begin
            if (paddr[2] == lcfc_pkg::REG_MAX_FRAME_LEN) begin
                r_max_frame_len <= pwdata[lcfc_pkg::FRAME_LEN_W-1:0];
            end else begin
                r_max_journal <= pwdata[lcfc_pkg::JOURNAL_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == lcfc_pkg::REG_MAX_JOURNAL_BYTES) begin
            prdata = {2'd0, r_max_journal};
        end else begin
            prdata = {6'd0, r_max_frame_len};
        end
    end

    assign o_cfg.max_frame_len     = r_max_frame_len;
    assign o_cfg.max_journal_bytes = r_max_journal;

endmodule

### design/lcfc_checker.sv
// ----------------------------------------------------------------------------
// lcfc_checker
// Port-level checks on the frame checker's result stream.
// ----------------------------------------------------------------------------
module lcfc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic        o_payload_valid,
    input  logic [7:0]  o_payload_byte,
    input  logic        o_frame_end,
    input  logic        o_frame_ok,
    input  logic [2:0]  o_error_code,
    input  logic [25:0] o_good_frames
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_good_frames)
            && $stable(o_payload_byte) && $stable(o_error_code))
        else $error("result changed while stalled");

    // once an error result is taken, nothing follows it
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_error_code != lcfc_pkg::ERR_NONE)
            |=> !o_out_valid)
        else $error("result after sticky error");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_payload_valid |-> o_payload_byte == 8'd0)
        else $error("non-payload byte not zero");

    a_ok_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ok |-> o_frame_end && o_payload_valid
            && o_error_code == lcfc_pkg::ERR_NONE)
        else $error("frame_ok without clean frame end");

    // with an empty result slot the input side must be open
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result slot");

endmodule

bind length_crc_frame_checker lcfc_checker u_lcfc_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: length_crc_frame_checker
// Feeds the checker a framed journal byte stream through the valid/ready
// channel and compares every result with a model of the block. The stream
// starts with a table of known frames, then runs random clean frames across
// several register settings. It ends with one broken sequence, because an
// error latches until reset. Both channels idle at random, and the result
// side holds off once long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;

    typedef struct packed {
        logic           pay_valid;
        logic [7:0]     pay_byte;
        logic           frame_end;
        logic           frame_ok;
        lcfc_pkg::t_err err;
        logic [25:0]    frames;
        logic [29:0]    nbytes;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        bit            typed;
        t_frame_result res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic        o_frame_end;
    logic        o_frame_ok;
    logic [2:0]  o_error_code;
    logic [25:0] o_good_frames;
    logic [29:0] o_prefix_bytes;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    length_crc_frame_checker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_frame_end     (o_frame_end),
        .o_frame_ok      (o_frame_ok),
        .o_error_code    (o_error_code),
        .o_good_frames   (o_good_frames),
        .o_prefix_bytes  (o_prefix_bytes),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // model state
    lcfc_pkg::t_cfg cfg;
    logic [3:0]     hdr_pos = 4'd0;
    logic           in_body = 1'b0;
    logic [31:0]    len_field = 32'd0;
    logic [31:0]    want_crc = 32'd0;
    logic [31:0]    body_crc = 32'hFFFFFFFF;
    logic [24:0]    body_left = 25'd0;
    logic [29:0]    stream_bytes = 30'd0;
    logic [25:0]    ok_frames = 26'd0;
    logic [29:0]    ok_bytes = 30'd0;
    lcfc_pkg::t_err latched_err = lcfc_pkg::ERR_NONE;

    t_frame_result pending[$];
    t_dir_row      dir_tab[26];
    int            fails = 0;
    int            sent = 0;
    int            cycle_count = 0;
    bit            hold_req = 1'b0;
    bit            tx_steady = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("length_crc_frame_checker test failed");
            $finish;
        end
    end

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ ((c[0] ^ b[i]) ? REFLECTED_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic int unsigned frame_limit();
        return {6'd0, (cfg.max_frame_len > lcfc_pkg::FRAME_CAP) ? lcfc_pkg::FRAME_CAP
                                                                : cfg.max_frame_len};
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic t_dir_row typed_row(logic [7:0] d, logic l, bit done,
                                           logic [25:0] fr, logic [29:0] nb);
        t_dir_row row;
        row = '0;
        row.data = d;
        row.last = l;
        row.typed = 1'b1;
        row.res.pay_valid = done;
        row.res.pay_byte = done ? d : 8'd0;
        row.res.frame_end = done;
        row.res.frame_ok = done;
        row.res.err = lcfc_pkg::ERR_NONE;
        row.res.frames = fr;
        row.res.nbytes = nb;
        return row;
    endfunction

    function automatic t_dir_row open_row(logic [7:0] d, logic l);
        t_dir_row row;
        row = '0;
        row.data = d;
        row.last = l;
        return row;
    endfunction

    // one stream byte through the model; no result once an error has latched
    task automatic predict_byte(input logic [7:0] b, input logic lst,
                                output bit has, output t_frame_result r);
        logic [2:0] pos;
        r = '0;
        has = (latched_err == lcfc_pkg::ERR_NONE);
        if (has) begin
            if ({1'b0, stream_bytes} + 31'd1 > {1'b0, cfg.max_journal_bytes}) begin
                latched_err = lcfc_pkg::ERR_JOURNAL;
            end else begin
                stream_bytes = stream_bytes + 30'd1;
                if (!in_body) begin
                    pos = hdr_pos[2:0];
                    if (pos < 3'd4) begin
                        len_field = ((pos == 3'd0) ? 32'd0 : len_field)
                                    | ({24'd0, b} << (8 * pos));
                    end else begin
                        want_crc = ((pos == 3'd4) ? 32'd0 : want_crc)
                                   | ({24'd0, b} << (8 * (pos - 3'd4)));
                    end
                    if (pos == 3'd7) begin
                        hdr_pos = 4'd0;
                        if (len_field == 32'd0 || len_field > frame_limit()) begin
                            latched_err = lcfc_pkg::ERR_FRAME_SIZE;
                        end else if (lst) begin
                            latched_err = lcfc_pkg::ERR_TRUNC_FRAME;
                        end else begin
                            in_body = 1'b1;
                            body_left = 25'(len_field - 32'd1);
                            body_crc = 32'hFFFFFFFF;
                        end
                    end else begin
                        hdr_pos = {1'b0, pos} + 4'd1;
                        if (lst) latched_err = lcfc_pkg::ERR_TRUNC_HDR;
                    end
                end else begin
                    r.pay_valid = 1'b1;
                    r.pay_byte = b;
                    body_crc = crc_step(body_crc, b);
                    if (body_left == 25'd0) begin
                        r.frame_end = 1'b1;
                        in_body = 1'b0;
                        if (~body_crc == want_crc) begin
                            r.frame_ok = 1'b1;
                            if (ok_frames != '1) ok_frames = ok_frames + 26'd1;
                            ok_bytes = ok_bytes + 30'd8 + len_field[29:0];
                        end else begin
                            latched_err = lcfc_pkg::ERR_CRC;
                        end
                    end else begin
                        body_left = body_left - 25'd1;
                        if (lst) latched_err = lcfc_pkg::ERR_TRUNC_FRAME;
                    end
                end
            end
            r.err = latched_err;
            r.frames = ok_frames;
            r.nbytes = ok_bytes;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input bit use_typed, input t_frame_result typed);
        int            gap;
        bit            has;
        t_frame_result r;
        gap = pick_gap(!tx_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_last <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(b, lst, has, r);
        if (has) pending.push_back(use_typed ? typed : r);
        sent++;
    endtask

    // header (length, CRC of the payload with crc_flip applied), then payload;
    // last_at is the frame byte index that carries last, -1 for none
    task automatic send_frame(input logic [31:0] len, input int unsigned n_pay,
                              input logic [31:0] crc_flip, input int last_at);
        logic [7:0]  body[$];
        logic [7:0]  b;
        logic [31:0] c;
        logic [63:0] hdr;
        c = 32'hFFFFFFFF;
        for (int i = 0; i < n_pay; i++) begin
            b = 8'($urandom);
            body.push_back(b);
            c = crc_step(c, b);
        end
        hdr = {~c ^ crc_flip, len};
        for (int i = 0; i < 8; i++) send_byte(hdr[8*i +: 8], i == last_at, 1'b0, '0);
        for (int i = 0; i < n_pay; i++) send_byte(body[i], (8 + i) == last_at, 1'b0, '0);
    endtask

    task automatic send_clean_frame();
        int unsigned lim, len, r;
        lim = frame_limit();
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, (lim < 16) ? lim : 16);
        else if (r < 95) len = $urandom_range(1, (lim < 120) ? lim : 120);
        else len = (lim < 120) ? lim : 120;
        if ($urandom_range(0, 5) == 0) tx_steady = !tx_steady;
        // a clean last on the final payload byte now and then
        send_frame(len, len, 32'd0, ($urandom_range(0, 3) == 0) ? int'(7 + len) : -1);
    endtask

    task automatic pause_for_idle();
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == lcfc_pkg::REG_MAX_FRAME_LEN) cfg.max_frame_len = val[25:0];
        else cfg.max_journal_bytes = val[29:0];
    endtask

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    task automatic check_result();
        t_frame_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, payload_byte %0h error_code %0d",
                     $time, o_payload_byte, o_error_code);
            fails++;
        end else begin
            want = pending.pop_front();
            cmp_field("payload_valid", 32'(want.pay_valid), 32'(o_payload_valid));
            cmp_field("payload_byte", 32'(want.pay_byte), 32'(o_payload_byte));
            cmp_field("frame_end", 32'(want.frame_end), 32'(o_frame_end));
            cmp_field("frame_ok", 32'(want.frame_ok), 32'(o_frame_ok));
            cmp_field("error_code", 32'(want.err), 32'(o_error_code));
            cmp_field("good_frames", 32'(want.frames), 32'(o_good_frames));
            cmp_field("prefix_bytes", 32'(want.nbytes), 32'(o_prefix_bytes));
        end
    endtask

    // result side: random stalls, steady stretches, one long hold on request
    initial begin
        int stall;
        int steady_left;
        bit steady;
        stall = 0;
        steady_left = 0;
        steady = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result();
            if (steady_left == 0) begin
                steady = ($urandom_range(0, 2) == 0);
                steady_left = $urandom_range(50, 300);
            end else begin
                steady_left--;
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 300;
            end else if (stall == 0) begin
                stall = pick_gap(!steady);
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned lim, len;
        int          start;
        logic [31:0] bad_len;
        cfg.max_frame_len = lcfc_pkg::FRAME_CAP;
        cfg.max_journal_bytes = lcfc_pkg::JOURNAL_CAP;

        // length 1, payload ff, crc ff000000
        dir_tab[0]  = typed_row(8'h01, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[1]  = typed_row(8'h00, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[2]  = typed_row(8'h00, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[3]  = typed_row(8'h00, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[4]  = typed_row(8'h00, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[5]  = typed_row(8'h00, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[6]  = typed_row(8'h00, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[7]  = typed_row(8'hFF, 1'b0, 1'b0, 26'd0, 30'd0);
        dir_tab[8]  = typed_row(8'hFF, 1'b0, 1'b1, 26'd1, 30'd9);
        // "123456789", crc cbf43926, clean last on the final byte
        dir_tab[9]  = typed_row(8'h09, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[10] = typed_row(8'h00, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[11] = typed_row(8'h00, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[12] = typed_row(8'h00, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[13] = typed_row(8'h26, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[14] = typed_row(8'h39, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[15] = typed_row(8'hF4, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[16] = typed_row(8'hCB, 1'b0, 1'b0, 26'd1, 30'd9);
        dir_tab[17] = open_row(8'h31, 1'b0);
        dir_tab[18] = open_row(8'h32, 1'b0);
        dir_tab[19] = open_row(8'h33, 1'b0);
        dir_tab[20] = open_row(8'h34, 1'b0);
        dir_tab[21] = open_row(8'h35, 1'b0);
        dir_tab[22] = open_row(8'h36, 1'b0);
        dir_tab[23] = open_row(8'h37, 1'b0);
        dir_tab[24] = open_row(8'h38, 1'b0);
        dir_tab[25] = typed_row(8'h39, 1'b1, 1'b1, 26'd2, 30'd26);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);
        end

        for (int p = 0; p < 6; p++) begin
            pause_for_idle();
            case (p)
                0: begin
                    write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, 32'(lcfc_pkg::FRAME_CAP));
                    write_reg(lcfc_pkg::REG_MAX_JOURNAL_BYTES, 32'(lcfc_pkg::JOURNAL_CAP));
                end
                1: write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, 32'd1);
                2: begin
                    // frame length above the cap: acts as the cap
                    write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, 32'h03FFFFFF);
                    write_reg(lcfc_pkg::REG_MAX_JOURNAL_BYTES, 32'h3FFFFFFF);
                    hold_req = 1'b1;
                end
                3: begin
                    write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, $urandom_range(2, 40));
                    write_reg(lcfc_pkg::REG_MAX_JOURNAL_BYTES,
                              $urandom_range(100000, 32'h3FFFFFFF));
                end
                4: write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, $urandom_range(2, 8));
                default: begin
                    write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, $urandom_range(1, 300));
                    write_reg(lcfc_pkg::REG_MAX_JOURNAL_BYTES, 32'(lcfc_pkg::JOURNAL_CAP));
                end
            endcase
            start = sent;
            while (sent - start < 300) send_clean_frame();
        end

        // the error latches until reset, so the run ends on one broken sequence
        pause_for_idle();
        write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, $urandom_range(16, 300));
        lim = frame_limit();
        len = $urandom_range(2, 16);
        case ($urandom_range(0, 7))
            0: send_frame(len, len, 32'd0, $urandom_range(0, 6));   // last inside header
            1: send_frame(len, len, 32'd0, 7);                      // last on eighth header byte
            2: send_frame(len, len, 32'd0, $urandom_range(8, 6 + len)); // last mid-payload
            3: send_frame(32'd0, 4, 32'd0, -1);                     // zero length
            4: begin
                bad_len = ($urandom_range(0, 1) == 0) ? lim + 1 : ($urandom | 32'h01000000);
                send_frame(bad_len, 4, 32'd0, -1);
            end
            5: send_frame(len, len, 32'd1 << $urandom_range(0, 31), -1); // crc mismatch
            6: begin
                pause_for_idle();
                write_reg(lcfc_pkg::REG_MAX_JOURNAL_BYTES,
                          stream_bytes + $urandom_range(0, 40));
                while (latched_err == lcfc_pkg::ERR_NONE) send_clean_frame();
            end
            default: begin
                pause_for_idle();
                write_reg(lcfc_pkg::REG_MAX_FRAME_LEN, 32'd0);   // rejects every frame
                send_frame(32'd1, 1, 32'd0, -1);
            end
        endcase
        // ignored once the error has latched
        repeat (20) send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);

        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fails == 0) begin
            $display("length_crc_frame_checker test passed");
        end else begin
            $display("length_crc_frame_checker test failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/lcfc_pkg.sv
design/lcfc_apb_regs.sv
design/length_crc_frame_checker.sv
design/lcfc_checker.sv
dv/tb.sv
